[src/virp_pkg.sv]
// Shared port codes, DAC component codes and read-source codes for the VGA register ports.
package virp_pkg;

  // Enumerated bus ports
  typedef enum logic [3:0] {
    PORT_GFX_IDX    = 4'd0,
    PORT_GFX_DATA   = 4'd1,
    PORT_SEQ_IDX    = 4'd2,
    PORT_SEQ_DATA   = 4'd3,
    PORT_CRT_IDX    = 4'd4,
    PORT_CRT_DATA   = 4'd5,
    PORT_ATTR_IDX   = 4'd6,
    PORT_ATTR_RD    = 4'd7,
    PORT_STATUS1    = 4'd8,
    PORT_MISC_RD    = 4'd9,
    PORT_MISC_WR    = 4'd10,
    PORT_DAC_RD_IDX = 4'd11,
    PORT_DAC_WR_IDX = 4'd12,
    PORT_DAC_DATA   = 4'd13,
    PORT_DAC_STATE  = 4'd14
  } port_t;

  // DAC component sequence
  typedef enum logic [1:0] {
    COMP_RED   = 2'd0,
    COMP_GREEN = 2'd1,
    COMP_BLUE  = 2'd2
  } comp_t;

  // Where the read byte of a beat comes from
  typedef enum logic [2:0] {
    SRC_DIRECT = 3'd0,
    SRC_GFX    = 3'd1,
    SRC_SEQ    = 3'd2,
    SRC_CRT    = 3'd3,
    SRC_ATTR   = 3'd4,
    SRC_PAL    = 3'd5
  } src_t;

  localparam int          PAS_BIT        = 5;
  localparam int          COMP_W         = 6;
  localparam int          ATTR_IDX_W     = 5;
  localparam logic [7:0]  DAC_STATE_READ = 8'h03;

endpackage

[src/virp_regfile.sv]
// Register file with one write port, one registered read port and per-entry valid bits.
module virp_regfile #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] vld_r;
  logic [WIDTH-1:0] rd_q_r;
  logic             rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q_r <= mem[rd_addr];
  end

  // Entries never written read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      rd_vld_r <= vld_r[rd_addr];
    end
  end

  assign rd_data = rd_vld_r ? rd_q_r : '0;

endmodule

[src/vga_indexed_register_ports.sv]
// Top level of the VGA indexed register ports: bus decode, index state and register files.
//
// One byte-wide bus beat (a read or a write to one of fifteen ports) is taken
// in every clock cycle: start is sampled at each rising edge and busy is tied
// low, so the block never holds a beat off. The read byte of each beat appears
// on out_read_data for exactly one cycle, with out_strobe high, in the cycle
// after the beat was taken; a write beat also returns a strobe, with a zero
// byte. The read byte is registered in the read ports of the register files
// and the palette, which are addressed straight from the index registers at
// the accepting edge. The sustained rate is one beat per cycle with no
// exceptions. The receiver must take every strobe; there is no
// back-pressure. All files, including the 18-bit palette, clear at reset
// through per-entry valid bits, so no clearing pass is needed and beats are
// accepted in the first cycle after reset. Data accesses whose index lies at
// or beyond a file's size are dropped and read as zero.
module vga_indexed_register_ports #(
  parameter int GRAPHICS_REGS   = 16,
  parameter int SEQUENCER_REGS  = 8,
  parameter int CRTC_REGS       = 32,
  parameter int ATTR_REGS       = 32,
  parameter int PALETTE_ENTRIES = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic       in_operation,
  input  logic [3:0] in_port,
  input  logic [7:0] in_write_data,
  output logic       out_strobe,
  output logic [7:0] out_read_data
);

  localparam int GFX_AW  = (GRAPHICS_REGS > 1) ? $clog2(GRAPHICS_REGS) : 1;
  localparam int SEQ_AW  = (SEQUENCER_REGS > 1) ? $clog2(SEQUENCER_REGS) : 1;
  localparam int CRT_AW  = (CRTC_REGS > 1) ? $clog2(CRTC_REGS) : 1;
  localparam int ATTR_AW = (ATTR_REGS > 1) ? $clog2(ATTR_REGS) : 1;
  localparam int PAL_AW  = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
  localparam int CW      = virp_pkg::COMP_W;
  localparam int PAL_W   = 3 * CW;

  // Index and mode state
  logic [7:0]                        gfx_idx_r, gfx_idx_nxt;
  logic [7:0]                        seq_idx_r, seq_idx_nxt;
  logic [7:0]                        crt_idx_r, crt_idx_nxt;
  logic [virp_pkg::ATTR_IDX_W-1:0]   attr_idx_r, attr_idx_nxt;
  logic                              attr_pas_r, attr_pas_nxt;
  logic                              attr_phase_r, attr_phase_nxt;
  logic [7:0]                        misc_r, misc_nxt;
  logic [7:0]                        dac_wr_idx_r, dac_wr_idx_nxt;
  logic [7:0]                        dac_rd_idx_r, dac_rd_idx_nxt;
  virp_pkg::comp_t                   dac_comp_r, dac_comp_nxt;
  logic                              dac_rmode_r, dac_rmode_nxt;
  logic [2*CW-1:0]                   dac_hold_r, dac_hold_nxt;

  // Result stage
  logic                              res_vld_r;
  virp_pkg::src_t                    res_src_r, res_src_nxt;
  logic [7:0]                        res_val_r, res_val_nxt;
  logic                              res_hit_r, res_hit_nxt;
  virp_pkg::comp_t                   res_comp_r;

  // File ports
  logic             gfx_we, seq_we, crt_we, attr_we, pal_we;
  logic [7:0]       gfx_rd, seq_rd, crt_rd, attr_rd;
  logic [PAL_W-1:0] pal_rd;
  logic [PAL_W-1:0] pal_wd;

  logic       acc;
  logic       wr;
  logic [CW-1:0] comp_in;
  logic       gfx_hit, seq_hit, crt_hit, attr_hit, pal_wr_hit, pal_rd_hit;

  assign busy    = 1'b0;
  assign acc     = start && !busy;
  assign wr      = in_operation;
  assign comp_in = in_write_data[CW-1:0];
  assign pal_wd  = {dac_hold_r, comp_in};

  assign gfx_hit    = {1'b0, gfx_idx_r} < 9'(GRAPHICS_REGS);
  assign seq_hit    = {1'b0, seq_idx_r} < 9'(SEQUENCER_REGS);
  assign crt_hit    = {1'b0, crt_idx_r} < 9'(CRTC_REGS);
  assign attr_hit   = {1'b0, attr_idx_r} < 6'(ATTR_REGS);
  assign pal_wr_hit = {1'b0, dac_wr_idx_r} < 9'(PALETTE_ENTRIES);
  assign pal_rd_hit = {1'b0, dac_rd_idx_r} < 9'(PALETTE_ENTRIES);

  // Decode one beat: update index state, steer file writes, pick the read source
  always_comb begin
    gfx_idx_nxt    = gfx_idx_r;
    seq_idx_nxt    = seq_idx_r;
    crt_idx_nxt    = crt_idx_r;
    attr_idx_nxt   = attr_idx_r;
    attr_pas_nxt   = attr_pas_r;
    attr_phase_nxt = attr_phase_r;
    misc_nxt       = misc_r;
    dac_wr_idx_nxt = dac_wr_idx_r;
    dac_rd_idx_nxt = dac_rd_idx_r;
    dac_comp_nxt   = dac_comp_r;
    dac_rmode_nxt  = dac_rmode_r;
    dac_hold_nxt   = dac_hold_r;
    gfx_we         = 1'b0;
    seq_we         = 1'b0;
    crt_we         = 1'b0;
    attr_we        = 1'b0;
    pal_we         = 1'b0;
    res_src_nxt    = virp_pkg::SRC_DIRECT;
    res_val_nxt    = '0;
    res_hit_nxt    = 1'b0;

    if (acc) begin
      case (virp_pkg::port_t'(in_port))
        virp_pkg::PORT_GFX_IDX: begin
          if (wr) gfx_idx_nxt = in_write_data;
          else    res_val_nxt = gfx_idx_r;
        end
        virp_pkg::PORT_GFX_DATA: begin
          gfx_we      = wr && gfx_hit;
          res_src_nxt = wr ? virp_pkg::SRC_DIRECT : virp_pkg::SRC_GFX;
          res_hit_nxt = gfx_hit;
        end
        virp_pkg::PORT_SEQ_IDX: begin
          if (wr) seq_idx_nxt = in_write_data;
          else    res_val_nxt = seq_idx_r;
        end
        virp_pkg::PORT_SEQ_DATA: begin
          seq_we      = wr && seq_hit;
          res_src_nxt = wr ? virp_pkg::SRC_DIRECT : virp_pkg::SRC_SEQ;
          res_hit_nxt = seq_hit;
        end
        virp_pkg::PORT_CRT_IDX: begin
          if (wr) crt_idx_nxt = in_write_data;
          else    res_val_nxt = crt_idx_r;
        end
        virp_pkg::PORT_CRT_DATA: begin
          crt_we      = wr && crt_hit;
          res_src_nxt = wr ? virp_pkg::SRC_DIRECT : virp_pkg::SRC_CRT;
          res_hit_nxt = crt_hit;
        end
        virp_pkg::PORT_ATTR_IDX: begin
          if (!wr) begin
            res_val_nxt = 8'({attr_pas_r, attr_idx_r});
          end else if (!attr_phase_r) begin
            attr_idx_nxt   = in_write_data[virp_pkg::ATTR_IDX_W-1:0];
            attr_pas_nxt   = in_write_data[virp_pkg::PAS_BIT];
            attr_phase_nxt = 1'b1;
          end else begin
            attr_we        = attr_hit;
            attr_phase_nxt = 1'b0;
          end
        end
        virp_pkg::PORT_ATTR_RD: begin
          if (!wr) begin
            res_src_nxt = virp_pkg::SRC_ATTR;
            res_hit_nxt = attr_hit;
          end
        end
        virp_pkg::PORT_STATUS1: begin
          if (!wr) attr_phase_nxt = 1'b0;
        end
        virp_pkg::PORT_MISC_RD: begin
          if (!wr) res_val_nxt = misc_r;
        end
        virp_pkg::PORT_MISC_WR: begin
          if (wr) misc_nxt = in_write_data;
        end
        virp_pkg::PORT_DAC_RD_IDX: begin
          if (wr) begin
            dac_rd_idx_nxt = in_write_data;
            dac_comp_nxt   = virp_pkg::COMP_RED;
            dac_rmode_nxt  = 1'b1;
          end
        end
        virp_pkg::PORT_DAC_WR_IDX: begin
          if (wr) begin
            dac_wr_idx_nxt = in_write_data;
            dac_comp_nxt   = virp_pkg::COMP_RED;
            dac_rmode_nxt  = 1'b0;
          end else begin
            res_val_nxt = dac_wr_idx_r;
          end
        end
        virp_pkg::PORT_DAC_DATA: begin
          if (wr) begin
            case (dac_comp_r)
              virp_pkg::COMP_RED: begin
                dac_hold_nxt = {comp_in, dac_hold_r[CW-1:0]};
                dac_comp_nxt = virp_pkg::COMP_GREEN;
              end
              virp_pkg::COMP_GREEN: begin
                dac_hold_nxt = {dac_hold_r[2*CW-1:CW], comp_in};
                dac_comp_nxt = virp_pkg::COMP_BLUE;
              end
              default: begin
                pal_we         = pal_wr_hit;
                dac_wr_idx_nxt = dac_wr_idx_r + 8'd1;
                dac_comp_nxt   = virp_pkg::COMP_RED;
              end
            endcase
          end else begin
            res_src_nxt = virp_pkg::SRC_PAL;
            res_hit_nxt = pal_rd_hit;
            case (dac_comp_r)
              virp_pkg::COMP_RED:   dac_comp_nxt = virp_pkg::COMP_GREEN;
              virp_pkg::COMP_GREEN: dac_comp_nxt = virp_pkg::COMP_BLUE;
              default: begin
                dac_rd_idx_nxt = dac_rd_idx_r + 8'd1;
                dac_comp_nxt   = virp_pkg::COMP_RED;
              end
            endcase
          end
        end
        virp_pkg::PORT_DAC_STATE: begin
          if (!wr) res_val_nxt = dac_rmode_r ? virp_pkg::DAC_STATE_READ : 8'h00;
        end
        default: begin
          // undefined port: drop the beat, read zero
        end
      endcase
    end
  end

  // Control and index registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gfx_idx_r    <= '0;
      seq_idx_r    <= '0;
      crt_idx_r    <= '0;
      attr_idx_r   <= '0;
      attr_pas_r   <= 1'b0;
      attr_phase_r <= 1'b0;
      misc_r       <= '0;
      dac_wr_idx_r <= '0;
      dac_rd_idx_r <= '0;
      dac_comp_r   <= virp_pkg::COMP_RED;
      dac_rmode_r  <= 1'b0;
      dac_hold_r   <= '0;
      res_vld_r    <= 1'b0;
    end else begin
      gfx_idx_r    <= gfx_idx_nxt;
      seq_idx_r    <= seq_idx_nxt;
      crt_idx_r    <= crt_idx_nxt;
      attr_idx_r   <= attr_idx_nxt;
      attr_pas_r   <= attr_pas_nxt;
      attr_phase_r <= attr_phase_nxt;
      misc_r       <= misc_nxt;
      dac_wr_idx_r <= dac_wr_idx_nxt;
      dac_rd_idx_r <= dac_rd_idx_nxt;
      dac_comp_r   <= dac_comp_nxt;
      dac_rmode_r  <= dac_rmode_nxt;
      dac_hold_r   <= dac_hold_nxt;
      res_vld_r    <= acc;
    end
  end

  // Result payload: hold the read source alongside the file read
  always_ff @(posedge clk) begin
    res_src_r  <= res_src_nxt;
    res_val_r  <= res_val_nxt;
    res_hit_r  <= res_hit_nxt;
    res_comp_r <= dac_comp_r;
  end

  virp_regfile #(.DEPTH(GRAPHICS_REGS), .WIDTH(8)) u_gfx_file (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (gfx_we),
    .wr_addr (gfx_idx_r[GFX_AW-1:0]),
    .wr_data (in_write_data),
    .rd_addr (gfx_idx_r[GFX_AW-1:0]),
    .rd_data (gfx_rd)
  );

  virp_regfile #(.DEPTH(SEQUENCER_REGS), .WIDTH(8)) u_seq_file (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (seq_we),
    .wr_addr (seq_idx_r[SEQ_AW-1:0]),
    .wr_data (in_write_data),
    .rd_addr (seq_idx_r[SEQ_AW-1:0]),
    .rd_data (seq_rd)
  );

  virp_regfile #(.DEPTH(CRTC_REGS), .WIDTH(8)) u_crt_file (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (crt_we),
    .wr_addr (crt_idx_r[CRT_AW-1:0]),
    .wr_data (in_write_data),
    .rd_addr (crt_idx_r[CRT_AW-1:0]),
    .rd_data (crt_rd)
  );

  virp_regfile #(.DEPTH(ATTR_REGS), .WIDTH(8)) u_attr_file (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (attr_we),
    .wr_addr (attr_idx_r[ATTR_AW-1:0]),
    .wr_data (in_write_data),
    .rd_addr (attr_idx_r[ATTR_AW-1:0]),
    .rd_data (attr_rd)
  );

  // Palette: write at the DAC write index, read at the DAC read index
  virp_regfile #(.DEPTH(PALETTE_ENTRIES), .WIDTH(PAL_W)) u_palette (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (pal_we),
    .wr_addr (dac_wr_idx_r[PAL_AW-1:0]),
    .wr_data (pal_wd),
    .rd_addr (dac_rd_idx_r[PAL_AW-1:0]),
    .rd_data (pal_rd)
  );

  // Select the read byte; drop out-of-range file reads to zero
  always_comb begin
    case (res_src_r)
      virp_pkg::SRC_GFX:  out_read_data = res_hit_r ? gfx_rd : 8'h00;
      virp_pkg::SRC_SEQ:  out_read_data = res_hit_r ? seq_rd : 8'h00;
      virp_pkg::SRC_CRT:  out_read_data = res_hit_r ? crt_rd : 8'h00;
      virp_pkg::SRC_ATTR: out_read_data = res_hit_r ? attr_rd : 8'h00;
      virp_pkg::SRC_PAL: begin
        if (!res_hit_r) begin
          out_read_data = 8'h00;
        end else begin
          case (res_comp_r)
            virp_pkg::COMP_RED:   out_read_data = 8'(pal_rd[3*CW-1:2*CW]);
            virp_pkg::COMP_GREEN: out_read_data = 8'(pal_rd[2*CW-1:CW]);
            default:              out_read_data = 8'(pal_rd[CW-1:0]);
          endcase
        end
      end
      default: out_read_data = res_val_r;
    endcase
  end

  assign out_strobe = res_vld_r;

`ifndef SYNTH
  // Every accepted beat yields exactly one strobe in the next cycle
  a_strobe_follows: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> out_strobe)
    else $error("missing result strobe after accepted beat");

  a_no_spurious_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    !acc |=> !out_strobe)
    else $error("result strobe without accepted beat");

  // Write beats read back as zero
  a_write_reads_zero: assert property (@(posedge clk) disable iff (!rst_n)
    acc && in_operation |=> out_read_data == 8'h00)
    else $error("write beat returned nonzero data");

  // Blue component write advances the DAC write index
  a_dac_wr_advance: assert property (@(posedge clk) disable iff (!rst_n)
    acc && in_operation && in_port == virp_pkg::PORT_DAC_DATA
      && dac_comp_r == virp_pkg::COMP_BLUE
    |=> dac_wr_idx_r == $past(dac_wr_idx_r) + 8'd1)
    else $error("DAC write index did not advance after blue");

  // Status 1 read returns the attribute flip-flop to the index phase
  a_status1_clears: assert property (@(posedge clk) disable iff (!rst_n)
    acc && !in_operation && in_port == virp_pkg::PORT_STATUS1 |=> !attr_phase_r)
    else $error("status 1 read left attribute in data phase");
`endif

endmodule

[bench/vga_indexed_register_ports_check.sv]
// Checker for the VGA register ports: predicts the read byte of every beat and compares it.
module vga_indexed_register_ports_check #(
  parameter int GRAPHICS_REGS   = 16,
  parameter int SEQUENCER_REGS  = 8,
  parameter int CRTC_REGS       = 32,
  parameter int ATTR_REGS       = 32,
  parameter int PALETTE_ENTRIES = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic       busy,
  input  logic       in_operation,
  input  logic [3:0] in_port,
  input  logic [7:0] in_write_data,
  input  logic       out_strobe,
  input  logic [7:0] out_read_data,
  output int         errors,
  output int         pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // Shadow copy of the register state
  logic [7:0]  gfx_index;
  logic [7:0]  gfx_regs [GRAPHICS_REGS];
  logic [7:0]  seq_sel;
  logic [7:0]  seq_regs [SEQUENCER_REGS];
  logic [7:0]  crt_sel;
  logic [7:0]  crt_regs [CRTC_REGS];
  logic [4:0]  attr_index;
  logic        attr_pas;
  logic        attr_data_phase;
  logic [7:0]  attr_regs [ATTR_REGS];
  logic [7:0]  misc_out;
  logic [7:0]  dac_wr_index;
  logic [7:0]  dac_rd_index;
  virp_pkg::comp_t dac_comp;
  logic        dac_reading;
  logic [11:0] dac_rg_hold;
  logic [17:0] palette [PALETTE_ENTRIES];

  logic [7:0]  expected_read_bytes [$];

  task automatic report_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    errors++;
  endtask

  // Apply one beat to the shadow state and return the byte it reads
  function automatic logic [7:0] predict_read_byte(input logic is_write, input logic [3:0] p,
                                                   input logic [7:0] wd);
    logic [7:0]  rd;
    logic [17:0] entry;
    rd = '0;
    case (p)
      virp_pkg::PORT_GFX_IDX: if (is_write) gfx_index = wd; else rd = gfx_index;
      virp_pkg::PORT_GFX_DATA: begin
        if (gfx_index < GRAPHICS_REGS) begin
          if (is_write) gfx_regs[gfx_index] = wd; else rd = gfx_regs[gfx_index];
        end
      end
      virp_pkg::PORT_SEQ_IDX: if (is_write) seq_sel = wd; else rd = seq_sel;
      virp_pkg::PORT_SEQ_DATA: begin
        if (seq_sel < SEQUENCER_REGS) begin
          if (is_write) seq_regs[seq_sel] = wd; else rd = seq_regs[seq_sel];
        end
      end
      virp_pkg::PORT_CRT_IDX: if (is_write) crt_sel = wd; else rd = crt_sel;
      virp_pkg::PORT_CRT_DATA: begin
        if (crt_sel < CRTC_REGS) begin
          if (is_write) crt_regs[crt_sel] = wd; else rd = crt_regs[crt_sel];
        end
      end
      virp_pkg::PORT_ATTR_IDX: begin
        if (!is_write) begin
          rd = {2'b00, attr_pas, attr_index};
        end else if (!attr_data_phase) begin
          attr_index      = wd[virp_pkg::ATTR_IDX_W-1:0];
          attr_pas        = wd[virp_pkg::PAS_BIT];
          attr_data_phase = 1'b1;
        end else begin
          if (attr_index < ATTR_REGS) attr_regs[attr_index] = wd;
          attr_data_phase = 1'b0;
        end
      end
      virp_pkg::PORT_ATTR_RD: begin
        if (!is_write && attr_index < ATTR_REGS) rd = attr_regs[attr_index];
      end
      virp_pkg::PORT_STATUS1: if (!is_write) attr_data_phase = 1'b0;
      virp_pkg::PORT_MISC_RD: if (!is_write) rd = misc_out;
      virp_pkg::PORT_MISC_WR: if (is_write) misc_out = wd;
      virp_pkg::PORT_DAC_RD_IDX: begin
        if (is_write) begin
          dac_rd_index = wd;
          dac_comp     = virp_pkg::COMP_RED;
          dac_reading  = 1'b1;
        end
      end
      virp_pkg::PORT_DAC_WR_IDX: begin
        if (is_write) begin
          dac_wr_index = wd;
          dac_comp     = virp_pkg::COMP_RED;
          dac_reading  = 1'b0;
        end else begin
          rd = dac_wr_index;
        end
      end
      virp_pkg::PORT_DAC_DATA: begin
        if (is_write) begin
          case (dac_comp)
            virp_pkg::COMP_RED: begin
              dac_rg_hold[11:6] = wd[virp_pkg::COMP_W-1:0];
              dac_comp = virp_pkg::COMP_GREEN;
            end
            virp_pkg::COMP_GREEN: begin
              dac_rg_hold[5:0] = wd[virp_pkg::COMP_W-1:0];
              dac_comp = virp_pkg::COMP_BLUE;
            end
            default: begin
              if (dac_wr_index < PALETTE_ENTRIES)
                palette[dac_wr_index] = {dac_rg_hold, wd[virp_pkg::COMP_W-1:0]};
              dac_wr_index = dac_wr_index + 8'd1;
              dac_comp = virp_pkg::COMP_RED;
            end
          endcase
        end else begin
          entry = '0;
          if (dac_rd_index < PALETTE_ENTRIES) entry = palette[dac_rd_index];
          case (dac_comp)
            virp_pkg::COMP_RED: begin
              rd = {2'b00, entry[17:12]};
              dac_comp = virp_pkg::COMP_GREEN;
            end
            virp_pkg::COMP_GREEN: begin
              rd = {2'b00, entry[11:6]};
              dac_comp = virp_pkg::COMP_BLUE;
            end
            default: begin
              rd = {2'b00, entry[5:0]};
              dac_rd_index = dac_rd_index + 8'd1;
              dac_comp = virp_pkg::COMP_RED;
            end
          endcase
        end
      end
      virp_pkg::PORT_DAC_STATE: begin
        if (!is_write) rd = dac_reading ? virp_pkg::DAC_STATE_READ : 8'h00;
      end
      default: ;
    endcase
    return is_write ? 8'h00 : rd;
  endfunction

  always @(posedge clk) begin
    logic [7:0] want;
    if (!rst_n) begin
      gfx_index       = '0;
      seq_sel         = '0;
      crt_sel         = '0;
      attr_index      = '0;
      attr_pas        = 1'b0;
      attr_data_phase = 1'b0;
      misc_out        = '0;
      dac_wr_index    = '0;
      dac_rd_index    = '0;
      dac_comp        = virp_pkg::COMP_RED;
      dac_reading     = 1'b0;
      dac_rg_hold     = '0;
      for (int i = 0; i < GRAPHICS_REGS; i++) gfx_regs[i] = '0;
      for (int i = 0; i < SEQUENCER_REGS; i++) seq_regs[i] = '0;
      for (int i = 0; i < CRTC_REGS; i++) crt_regs[i] = '0;
      for (int i = 0; i < ATTR_REGS; i++) attr_regs[i] = '0;
      for (int i = 0; i < PALETTE_ENTRIES; i++) palette[i] = '0;
      expected_read_bytes.delete();
      errors = 0;
    end else begin
      // Match the strobe of this edge first: it belongs to an earlier beat
      if (out_strobe !== 1'b0) begin
        if (expected_read_bytes.size() == 0) begin
          report_mismatch($sformatf("strobe %b with no beat outstanding, read_data %h",
                                    out_strobe, out_read_data));
        end else begin
          want = expected_read_bytes.pop_front();
          if (out_strobe !== 1'b1 || out_read_data !== want)
            report_mismatch($sformatf("strobe %b read_data %h, expected %h",
                                      out_strobe, out_read_data, want));
        end
      end
      if (start === 1'b1 && busy === 1'b0)
        expected_read_bytes.push_back(predict_read_byte(in_operation, in_port,
                                                        in_write_data));
    end
    pending <= expected_read_bytes.size();
  end

endmodule

[bench/vga_indexed_register_ports_test.sv]
// Testbench top for the VGA register ports: clock, reset, bus stimulus and the verdict.
module vga_indexed_register_ports_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int GRAPHICS_REGS   = 16;
  localparam int SEQUENCER_REGS  = 8;
  localparam int CRTC_REGS       = 32;
  localparam int ATTR_REGS       = 32;
  localparam int PALETTE_ENTRIES = 256;

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // Random beats per idling phase; three phases make up the random part
  localparam int PHASE_BEATS = 505;
  // Far above the slowest legal run (about 1550 beats with long sender gaps)
  localparam int CYCLE_LIMIT = 200000;

  logic       clk;
  logic       rst_n;
  logic       start;
  logic       busy;
  logic       in_operation;
  logic [3:0] in_port;
  logic [7:0] in_write_data;
  logic       out_strobe;
  logic [7:0] out_read_data;

  int errors;
  int pending;
  int beats_sent;
  int idle_pct;
  logic [7:0] last_dac_base;

  vga_indexed_register_ports #(
    .GRAPHICS_REGS  (GRAPHICS_REGS),
    .SEQUENCER_REGS (SEQUENCER_REGS),
    .CRTC_REGS      (CRTC_REGS),
    .ATTR_REGS      (ATTR_REGS),
    .PALETTE_ENTRIES(PALETTE_ENTRIES)
  ) uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_operation (in_operation),
    .in_port      (in_port),
    .in_write_data(in_write_data),
    .out_strobe   (out_strobe),
    .out_read_data(out_read_data)
  );

  // The checker sits beside the block, predicts every beat and counts mismatches
  vga_indexed_register_ports_check #(
    .GRAPHICS_REGS  (GRAPHICS_REGS),
    .SEQUENCER_REGS (SEQUENCER_REGS),
    .CRTC_REGS      (CRTC_REGS),
    .ATTR_REGS      (ATTR_REGS),
    .PALETTE_ENTRIES(PALETTE_ENTRIES)
  ) read_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_operation (in_operation),
    .in_port      (in_port),
    .in_write_data(in_write_data),
    .out_strobe   (out_strobe),
    .out_read_data(out_read_data),
    .errors       (errors),
    .pending      (pending)
  );

  // Free-running clock, 10 ns period
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Hold the sender idle for a random gap, then present one beat at the falling
  // edge and keep it up until a rising edge takes it (start high, busy low).
  task automatic send_access(input logic op, input logic [3:0] p, input logic [7:0] wd);
    while (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
      @(posedge clk);
    end
    @(negedge clk);
    start         <= 1'b1;
    in_operation  <= op;
    in_port       <= p;
    in_write_data <= wd;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    beats_sent++;
  endtask

  // Drop start and hold off until every outstanding beat has returned its byte
  task automatic wait_for_results();
    @(negedge clk);
    start <= 1'b0;
    while (pending != 0) @(posedge clk);
  endtask

  // Mostly an index inside the file, now and then any byte to hit the drop path
  function automatic logic [7:0] pick_index(input int size);
    if ($urandom_range(0, 4) == 0) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(0, size - 1));
  endfunction

  function automatic logic [7:0] any_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic any_op();
    return $urandom_range(0, 1) ? OP_WRITE : OP_READ;
  endfunction

  // One short access sequence: mostly well-formed driver patterns with random
  // content, the rest broken patterns and plain noise over all sixteen codes.
  task automatic send_random_sequence();
    int kind;
    int n;
    int size;
    logic [3:0] ip;
    logic [3:0] dp;
    kind = $urandom_range(0, 9);
    case (kind)
      0, 1, 2: begin
        // Index/data pair: set the index, then a few data beats in either direction
        case (kind)
          0: begin
            ip = virp_pkg::PORT_GFX_IDX; dp = virp_pkg::PORT_GFX_DATA; size = GRAPHICS_REGS;
          end
          1: begin
            ip = virp_pkg::PORT_SEQ_IDX; dp = virp_pkg::PORT_SEQ_DATA; size = SEQUENCER_REGS;
          end
          default: begin
            ip = virp_pkg::PORT_CRT_IDX; dp = virp_pkg::PORT_CRT_DATA; size = CRTC_REGS;
          end
        endcase
        send_access(OP_WRITE, ip, pick_index(size));
        n = $urandom_range(1, 3);
        repeat (n) send_access(any_op(), dp, any_byte());
        if ($urandom_range(0, 3) == 0) send_access(OP_READ, ip, any_byte());
      end
      3: begin
        // Attribute access: usually sync the flip-flop first, then index and data
        if ($urandom_range(0, 3) != 0)
          send_access(OP_READ, virp_pkg::PORT_STATUS1, any_byte());
        send_access(OP_WRITE, virp_pkg::PORT_ATTR_IDX, any_byte());
        case ($urandom_range(0, 2))
          0: send_access(OP_WRITE, virp_pkg::PORT_ATTR_IDX, any_byte());
          1: send_access(OP_READ, virp_pkg::PORT_ATTR_RD, any_byte());
          default: send_access(OP_READ, virp_pkg::PORT_ATTR_IDX, any_byte());
        endcase
        if ($urandom_range(0, 1)) send_access(OP_READ, virp_pkg::PORT_ATTR_RD, any_byte());
      end
      4: begin
        // Palette load: whole triplets, sometimes cut short
        last_dac_base = any_byte();
        send_access(OP_WRITE, virp_pkg::PORT_DAC_WR_IDX, last_dac_base);
        n = 3 * $urandom_range(1, 3);
        if ($urandom_range(0, 4) == 0) n = n - $urandom_range(1, 2);
        repeat (n) send_access(OP_WRITE, virp_pkg::PORT_DAC_DATA, any_byte());
        if ($urandom_range(0, 1))
          send_access(OP_READ, virp_pkg::PORT_DAC_WR_IDX, any_byte());
        if ($urandom_range(0, 3) == 0)
          send_access(OP_READ, virp_pkg::PORT_DAC_STATE, any_byte());
      end
      5: begin
        // Palette read-back, often from the entry last loaded
        send_access(OP_WRITE, virp_pkg::PORT_DAC_RD_IDX,
                    $urandom_range(0, 1) ? last_dac_base : any_byte());
        n = 3 * $urandom_range(1, 2);
        if ($urandom_range(0, 4) == 0) n = n - 1;
        repeat (n) send_access(OP_READ, virp_pkg::PORT_DAC_DATA, any_byte());
        if ($urandom_range(0, 1)) send_access(OP_READ, virp_pkg::PORT_DAC_STATE, any_byte());
      end
      6: begin
        send_access(OP_WRITE, virp_pkg::PORT_MISC_WR, any_byte());
        send_access(OP_READ, virp_pkg::PORT_MISC_RD, any_byte());
        if ($urandom_range(0, 2) == 0) send_access(any_op(), virp_pkg::PORT_MISC_WR, any_byte());
        if ($urandom_range(0, 2) == 0) send_access(any_op(), virp_pkg::PORT_MISC_RD, any_byte());
      end
      default: begin
        // Noise: any direction, any of the sixteen codes, any byte
        n = $urandom_range(1, 4);
        repeat (n) send_access(any_op(), 4'($urandom_range(0, 15)), any_byte());
      end
    endcase
  endtask

  task automatic run_random_phase(input int pct);
    int goal;
    idle_pct = pct;
    goal = beats_sent + PHASE_BEATS;
    while (beats_sent < goal) send_random_sequence();
  endtask

  // Cycle budget: end the run as failed if it never finishes
  initial begin
    for (int n = 0; n < CYCLE_LIMIT; n++) @(posedge clk);
    $display("vga_indexed_register_ports regression: fail");
    $finish;
  end

  initial begin
    rst_n         = 1'b0;
    start         = 1'b0;
    in_operation  = OP_READ;
    in_port       = virp_pkg::PORT_GFX_IDX;
    in_write_data = 8'h00;
    beats_sent    = 0;
    idle_pct      = 27;
    last_dac_base = 8'h00;

    // Hold reset, then release it at a falling edge
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: index past the file drops the write and reads zero
    send_access(OP_WRITE, virp_pkg::PORT_GFX_IDX,  8'hFF);
    send_access(OP_WRITE, virp_pkg::PORT_GFX_DATA, 8'hAA);
    send_access(OP_READ,  virp_pkg::PORT_GFX_DATA, 8'h00);
    send_access(OP_READ,  virp_pkg::PORT_GFX_IDX,  8'h00);
    // Top entry of the graphics, sequencer and CRTC files; an extreme byte into graphics
    send_access(OP_WRITE, virp_pkg::PORT_GFX_IDX,  8'h0F);
    send_access(OP_WRITE, virp_pkg::PORT_GFX_DATA, 8'hFF);
    send_access(OP_READ,  virp_pkg::PORT_GFX_DATA, 8'hFF);
    send_access(OP_WRITE, virp_pkg::PORT_SEQ_IDX,  8'h07);
    send_access(OP_WRITE, virp_pkg::PORT_SEQ_DATA, 8'h5A);
    send_access(OP_READ,  virp_pkg::PORT_SEQ_DATA, 8'h00);
    send_access(OP_WRITE, virp_pkg::PORT_CRT_IDX,  8'h1F);
    send_access(OP_WRITE, virp_pkg::PORT_CRT_DATA, 8'hC3);
    send_access(OP_READ,  virp_pkg::PORT_CRT_DATA, 8'h00);
    // Attribute: index with palette source, data write, status 1 resync
    send_access(OP_WRITE, virp_pkg::PORT_ATTR_IDX, 8'hFF);
    send_access(OP_WRITE, virp_pkg::PORT_ATTR_IDX, 8'hA5);
    send_access(OP_READ,  virp_pkg::PORT_ATTR_RD,  8'h00);
    send_access(OP_READ,  virp_pkg::PORT_ATTR_IDX, 8'h00);
    send_access(OP_WRITE, virp_pkg::PORT_ATTR_IDX, 8'h01);
    send_access(OP_READ,  virp_pkg::PORT_STATUS1,  8'hFF);
    send_access(OP_WRITE, virp_pkg::PORT_ATTR_IDX, 8'h00);
    // Misc output and wrong-direction accesses
    send_access(OP_WRITE, virp_pkg::PORT_MISC_WR,  8'hFF);
    send_access(OP_READ,  virp_pkg::PORT_MISC_RD,  8'h00);
    send_access(OP_READ,  virp_pkg::PORT_MISC_WR,  8'h00);
    send_access(OP_WRITE, virp_pkg::PORT_MISC_RD,  8'h00);
    // DAC: load entry 255, wrap the write index, read it back in read mode
    send_access(OP_WRITE, virp_pkg::PORT_DAC_WR_IDX, 8'hFF);
    send_access(OP_WRITE, virp_pkg::PORT_DAC_DATA,   8'hFF);
    send_access(OP_WRITE, virp_pkg::PORT_DAC_DATA,   8'h80);
    send_access(OP_WRITE, virp_pkg::PORT_DAC_DATA,   8'h3F);
    send_access(OP_READ,  virp_pkg::PORT_DAC_WR_IDX, 8'h00);
    send_access(OP_WRITE, virp_pkg::PORT_DAC_RD_IDX, 8'hFF);
    send_access(OP_READ,  virp_pkg::PORT_DAC_STATE,  8'h00);
    repeat (3) send_access(OP_READ, virp_pkg::PORT_DAC_DATA, 8'h00);
    send_access(OP_WRITE, 4'hF, 8'hFF);

    // Random: three idling phases, a full drain between them
    run_random_phase(27);
    wait_for_results();
    run_random_phase(63);
    wait_for_results();
    run_random_phase(0);

    // Drain, then keep clocking to catch stray strobes before the verdict
    wait_for_results();
    repeat (4) @(posedge clk);

    if (errors == 0 && pending == 0)
      $display("vga_indexed_register_ports regression: pass");
    else
      $display("vga_indexed_register_ports regression: fail");
    $finish;
  end

endmodule
